FILE: rtl/smx_pkg.sv
// Shared widths and defaults for the softmax normalizer.
`default_nettype none
package smx_pkg;
  localparam int WEIGHT_W      = 16;
  localparam int EXP_W         = 32;
  localparam int SUM_W         = 40;
  localparam int PROB_W        = 16;
  localparam int DEF_MAX_ITEMS = 64;
endpackage
`default_nettype wire

FILE: rtl/softmax_normalizer_top.sv
// Softmax normalizer top: exp store, running sum and serial probability divider.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+---------------------------
//  input    | in_weight, in_last_weight                      | start & !busy takes a word
//  result   | out_probability, out_last_probability,         | out_valid strobe, 1 cycle
//           | out_overflowed                                 |
//
// Steps: each stored weight runs the exp unit for 63 series terms, each of
// 4 multiply digits, 17 divide digits and 1 accumulate, then finish, round,
// store and accept; a dropped word is taken without running the exp unit.
// Each result takes a store read, a load, 17 quotient bits from the
// bit-serial divider by 2*sum, and an emit.
// Reset (rst_n low, synchronous) clears count, sum and overflow flag; the
// exp store is not cleared, only entries written in the current set are read.
// busy is high for the whole exp and emit phase; the receiver cannot stall.
`default_nettype none
module softmax_normalizer_top #(
  parameter int MAX_ITEMS = smx_pkg::DEF_MAX_ITEMS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [smx_pkg::WEIGHT_W-1:0] in_weight,
  input  wire logic                         in_last_weight,
  output logic                              out_valid,
  output logic [smx_pkg::PROB_W-1:0]        out_probability,
  output logic                              out_last_probability,
  output logic                              out_overflowed
);
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int EW    = smx_pkg::EXP_W;
  localparam int SW    = smx_pkg::SUM_W;
  localparam int NUM_W = EW + 17;   // exp << 17, plus sum
  localparam int REM_W = SW + 2;    // holds up to twice 2*sum

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_RD, S_LOAD, S_DIV, S_EMIT
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SW-1:0]        sum_r;
  logic                 ovf_r;
  logic                 last_r;
  logic [EW-1:0]        rdata_r;
  logic [REM_W-1:0]     rem_r;
  logic [16:0]          nlo_r;
  logic [16:0]          q_r;
  logic [4:0]           bcnt_r;
  logic                 out_valid_r;
  logic [15:0]          out_prob_r;
  logic                 out_last_r;
  logic                 out_ovf_r;

  logic [EW-1:0]        mem [MAX_ITEMS];

  logic                 full;
  logic                 take;
  logic                 exp_start;
  logic                 exp_done;
  logic [EW-1:0]        exp_res;
  logic                 mem_we;
  logic [NUM_W-1:0]     num;
  logic [REM_W-1:0]     dsr;
  logic [REM_W-1:0]     trial;
  logic                 ge;
  logic                 is_last;

  assign busy      = (state_r != S_IDLE);
  assign full      = (cnt_r >= CNT_W'(MAX_ITEMS));
  assign take      = start && !busy;
  assign exp_start = take && !full;
  assign mem_we    = (state_r == S_WAIT) && exp_done;

  smx_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (exp_start),
    .weight (in_weight),
    .done   (exp_done),
    .result (exp_res)
  );

  // store: write at fill position, registered read at emit index
  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt_r[IDX_W-1:0]] <= exp_res;
    if (state_r == S_RD) rdata_r <= mem[idx_r];
  end

  // probability = floor((e*2^17 + S) / (2S)), one quotient bit a cycle
  assign num     = {rdata_r, 17'b0} + NUM_W'(sum_r);
  assign dsr     = {1'b0, sum_r, 1'b0};
  assign trial   = {rem_r[REM_W-2:0], nlo_r[16]};
  assign ge      = (trial >= dsr);
  assign is_last = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_EMIT);
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            last_r <= in_last_weight;
            if (!full) begin
              state_r <= S_WAIT;
            end else begin
              ovf_r <= 1'b1;            // word dropped, set still closes on last
              if (in_last_weight) begin
                idx_r   <= '0;
                state_r <= S_RD;
              end
            end
          end
        end
        S_WAIT: begin
          if (exp_done) begin
            sum_r <= sum_r + SW'(exp_res);
            cnt_r <= cnt_r + CNT_W'(1);
            if (last_r) begin
              idx_r   <= '0;
              state_r <= S_RD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_RD: state_r <= S_LOAD;
        S_LOAD: begin
          rem_r   <= REM_W'(num[NUM_W-1:17]);
          nlo_r   <= num[16:0];
          q_r     <= '0;
          bcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= ge ? (trial - dsr) : trial;
          q_r    <= {q_r[15:0], ge};
          nlo_r  <= {nlo_r[15:0], 1'b0};
          bcnt_r <= bcnt_r + 5'd1;
          if (bcnt_r == 5'd16) state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_prob_r  <= q_r[16] ? 16'hFFFF : q_r[15:0];   // ratio of 1.0 saturates
          out_last_r  <= is_last;
          out_ovf_r   <= ovf_r;
          if (is_last) begin
            cnt_r   <= '0;
            sum_r   <= '0;
            ovf_r   <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_probability      = out_prob_r;
  assign out_last_probability = out_last_r;
  assign out_overflowed       = out_ovf_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobes back to back");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !full) |=> busy)
    else $error("stored word did not start exp unit");

  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (cnt_r == '0 && sum_r == '0 && !ovf_r))
    else $error("set state not cleared after last result");
endmodule
`default_nettype wire

FILE: rtl/smx_exp.sv
// Series exponential unit: Q4.12 weight in, Q12.20 exp out, digit-serial mul/div.
`default_nettype none
module smx_exp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [smx_pkg::WEIGHT_W-1:0] weight,
  output logic                             done,
  output logic [smx_pkg::EXP_W-1:0]        result
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_ACC, S_FIN, S_RND
  } state_t;

  state_t       state_r;
  logic         neg_r;
  logic [15:0]  a_sh_r;
  logic [61:0]  term_r;
  logic [63:0]  plus_r;
  logic [63:0]  minus_r;
  logic [63:0]  diff_r;
  logic [77:0]  prod_r;
  logic [67:0]  dvd_r;
  logic [5:0]   rem_r;
  logic [5:0]   k_r;
  logic [1:0]   mcnt_r;
  logic [4:0]   dcnt_r;
  logic         done_r;
  logic [31:0]  result_r;

  logic [15:0]  a_abs;
  logic [77:0]  prod_nxt;
  logic [67:0]  dvd_nxt;
  logic [5:0]   rem_nxt;
  logic [64:0]  rnd_sum;

  assign a_abs    = weight[15] ? (16'd0 - weight) : weight;
  assign prod_nxt = {prod_r[73:0], 4'b0} + ({16'b0, term_r} * {74'b0, a_sh_r[15:12]});
  assign rnd_sum  = {1'b0, diff_r} + 65'h0_8000_0000;

  // four restoring steps per cycle by the small divisor k
  always_comb begin
    logic [5:0] r;
    logic [6:0] t;
    logic [3:0] qd;
    r  = rem_r;
    qd = 4'b0;
    for (int j = 3; j >= 0; j--) begin
      t = {r, dvd_r[64+j]};
      if (t >= {1'b0, k_r}) begin
        r     = 6'(t - {1'b0, k_r});
        qd[j] = 1'b1;
      end else begin
        r = t[5:0];
      end
    end
    rem_nxt = r;
    dvd_nxt = {dvd_r[63:0], qd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == S_RND);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            neg_r   <= weight[15];
            a_sh_r  <= a_abs;
            term_r  <= 62'd1 << 52;
            plus_r  <= 64'd1 << 52;
            minus_r <= 64'd0;
            k_r     <= 6'd1;
            prod_r  <= 78'd0;
            mcnt_r  <= 2'd0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= prod_nxt;
          a_sh_r <= {a_sh_r[11:0], a_sh_r[15:12]};
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd3) begin
            dvd_r   <= {2'b0, prod_nxt[77:12]};
            rem_r   <= 6'd0;
            dcnt_r  <= 5'd0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          dvd_r  <= dvd_nxt;
          rem_r  <= rem_nxt;
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd16) state_r <= S_ACC;
        end
        S_ACC: begin
          term_r <= dvd_r[61:0];
          if (neg_r && k_r[0]) minus_r <= minus_r + {2'b0, dvd_r[61:0]};
          else                 plus_r  <= plus_r + {2'b0, dvd_r[61:0]};
          k_r    <= k_r + 6'd1;
          prod_r <= 78'd0;
          mcnt_r <= 2'd0;
          if (k_r == 6'd63) state_r <= S_FIN;
          else              state_r <= S_MUL;
        end
        S_FIN: begin
          diff_r  <= (plus_r >= minus_r) ? (plus_r - minus_r) : 64'd0;
          state_r <= S_RND;
        end
        S_RND: begin
          result_r <= rnd_sum[63:32];
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;
endmodule
`default_nettype wire

FILE: tb/softmax_normalizer_top_tb.sv
// Self-checking testbench for the softmax normalizer: random and directed weight sets.
`default_nettype none
module softmax_normalizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAP = smx_pkg::DEF_MAX_ITEMS;

  // one input word: a weight and the end-of-set mark
  typedef struct packed {
    logic [smx_pkg::WEIGHT_W-1:0] weight;
    logic                         last;
  } weight_word_t;

  // one expected result word
  typedef struct packed {
    logic [smx_pkg::PROB_W-1:0] prob;
    logic                       last;
    logic                       ovf;
  } prob_word_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [smx_pkg::WEIGHT_W-1:0] in_weight = '0;
  logic                         in_last_weight = 1'b0;
  logic                         out_valid;
  logic [smx_pkg::PROB_W-1:0]   out_probability;
  logic                         out_last_probability;
  logic                         out_overflowed;

  weight_word_t weight_fifo[$];
  prob_word_t   expected_probs[$];
  int           error_count = 0;
  int           gap_left = 0;
  bit           calm_mode = 1'b0;

  // shadow copy of the set state
  logic [smx_pkg::EXP_W-1:0] shadow_exps[SET_CAP];
  logic [smx_pkg::SUM_W-1:0] shadow_sum = '0;
  int                        shadow_count = 0;
  bit                        shadow_ovf = 1'b0;

  always #10 clk = ~clk;

  softmax_normalizer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_weight           (in_weight),
    .in_last_weight      (in_last_weight),
    .out_valid           (out_valid),
    .out_probability     (out_probability),
    .out_last_probability(out_last_probability),
    .out_overflowed      (out_overflowed)
  );

  // exp(weight) in Q12.20: Taylor series worked in Q12.52, odd terms
  // subtracted for negative weights, then rounded half up.
  function automatic logic [smx_pkg::EXP_W-1:0] exp_q12_20(logic [smx_pkg::WEIGHT_W-1:0] w);
    longint unsigned a, term, plus, minus, diff, d, hi, lo, ph, qh, r, pl;
    bit neg;
    neg   = w[smx_pkg::WEIGHT_W-1];
    a     = neg ? (64'd65536 - w) : w;
    term  = 64'd1 << 52;
    plus  = term;
    minus = 0;
    for (int k = 1; k < 64; k++) begin
      // exact floor(term * a / d) split in two halves to stay in 64 bits
      d    = 64'd4096 * k;
      hi   = term >> 32;
      lo   = term & 64'hFFFF_FFFF;
      ph   = hi * a;
      qh   = ph / d;
      r    = ph % d;
      pl   = (r << 32) + lo * a;
      term = (qh << 32) + pl / d;
      if (neg && k[0]) minus += term;
      else plus += term;
    end
    diff = (plus >= minus) ? plus - minus : 0;
    return smx_pkg::EXP_W'((diff + (64'd1 << 31)) >> 32);
  endfunction

  // Track one accepted word; on the closing word queue one probability per stored weight.
  task automatic predict_probs(weight_word_t wd);
    longint unsigned e, s, p;
    prob_word_t pw;
    if (shadow_count < SET_CAP) begin
      shadow_exps[shadow_count] = exp_q12_20(wd.weight);
      shadow_sum = shadow_sum + shadow_exps[shadow_count];
      shadow_count++;
    end else begin
      shadow_ovf = 1'b1;
    end
    if (wd.last) begin
      s = shadow_sum;
      for (int i = 0; i < shadow_count; i++) begin
        e = shadow_exps[i];
        p = (s == 0) ? 0 : ((e << 17) + s) / (s << 1);
        if (p > 65535) p = 65535;
        pw.prob = smx_pkg::PROB_W'(p);
        pw.last = (i == shadow_count - 1);
        pw.ovf  = shadow_ovf;
        expected_probs = {expected_probs, pw};
      end
      shadow_sum   = '0;
      shadow_count = 0;
      shadow_ovf   = 1'b0;
    end
  endtask

  // mostly back-to-back, sometimes short pauses, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_mode || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Driver: a word is taken at an edge with start high and busy low.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_probs('{weight: in_weight, last: in_last_weight});
        if (in_last_weight) calm_mode <= ($urandom_range(0, 3) == 0);
        gap_left = pick_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (weight_fifo.size() > 0) begin
          weight_word_t nx;
          nx = weight_fifo.pop_front();
          in_weight      <= nx.weight;
          in_last_weight <= nx.last;
          start          <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result word checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_probs.size() == 0) begin
        $display("%0t: unexpected result prob=%0d last=%0b ovf=%0b", $time,
                 out_probability, out_last_probability, out_overflowed);
        error_count++;
      end else begin
        prob_word_t ex;
        ex = expected_probs.pop_front();
        if (out_probability !== ex.prob) begin
          $display("%0t: probability expected %0d actual %0d", $time, ex.prob,
                   out_probability);
          error_count++;
        end
        if (out_last_probability !== ex.last) begin
          $display("%0t: last_probability expected %0b actual %0b", $time, ex.last,
                   out_last_probability);
          error_count++;
        end
        if (out_overflowed !== ex.ovf) begin
          $display("%0t: overflowed expected %0b actual %0b", $time, ex.ovf,
                   out_overflowed);
          error_count++;
        end
      end
    end
  end

  task automatic queue_word(logic [smx_pkg::WEIGHT_W-1:0] w, logic lst);
    weight_word_t wd;
    wd.weight   = w;
    wd.last     = lst;
    weight_fifo = {weight_fifo, wd};
  endtask

  // a set of n random weights; narrow sets keep the ratios away from saturation
  task automatic queue_random_set(int n);
    bit narrow;
    logic [smx_pkg::WEIGHT_W-1:0] w;
    narrow = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      w = narrow ? smx_pkg::WEIGHT_W'($signed($urandom_range(0, 16384)) - 8192)
                 : smx_pkg::WEIGHT_W'($urandom);
      queue_word(w, i == n - 1);
    end
  endtask

  initial begin
    int stored;
    int n;

    // single-item sets: ratio is exactly one and saturates
    queue_word(16'h7FFF, 1'b1);
    queue_word(16'h8000, 1'b1);
    queue_word(16'h0000, 1'b1);
    // field extremes together in one set
    queue_word(16'h0000, 1'b0);
    queue_word(16'h7FFF, 1'b0);
    queue_word(16'h8000, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'h0001, 1'b0);
    queue_word(16'h1000, 1'b1);
    // equal weights split evenly
    queue_word(16'hF000, 1'b0);
    queue_word(16'hF000, 1'b0);
    queue_word(16'hF000, 1'b0);
    queue_word(16'hF000, 1'b1);
    // full capacity exactly, no drop
    queue_random_set(SET_CAP);
    // over capacity: two dropped words, the closing one among them
    queue_random_set(SET_CAP + 2);
    stored = 15 + 2 * SET_CAP;

    // random sets, mostly small
    while (stored < 370) begin
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      queue_random_set(n);
      stored += n;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all words taken, every result seen, then a short settle
    wait (weight_fifo.size() == 0 && !start);
    wait (expected_probs.size() == 0 && !busy);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_probs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // timeout well beyond the slowest run, to end a hung simulation
  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
